@@ sv/daily_schedule_slot_finder_unit_defines.svh @@
// Assertion macros shared by the schedule slot finder RTL.
`ifndef DAILY_SCHEDULE_SLOT_FINDER_UNIT_DEFINES_SVH
`define DAILY_SCHEDULE_SLOT_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DSSF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dssf assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DSSF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dssf assertion failed");

`endif

@@ sv/dssf_pkg.sv @@
// Types and constants of the daily schedule slot finder.
package dssf_pkg;

	localparam int MAX_EVENTS_DEF = 8;
	localparam int COUNT_W        = 4;
	localparam int TIME_W         = 11;
	localparam int MIN_PER_HOUR   = 60;
	localparam int LAST_HOUR      = 23;
	localparam int LAST_MINUTE    = 59;
	localparam int DAY_MINUTES    = LAST_HOUR * MIN_PER_HOUR + LAST_MINUTE + 1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] entry_index;
		logic [4:0] event_hour;
		logic [5:0] event_minute;
		logic       event_on;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
	} req_t;

	typedef struct packed {
		logic [2:0]  current_index;
		logic [2:0]  next_index;
		logic        relay_on;
		logic [10:0] minutes_left;
		logic        table_empty;
	} rsp_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic       on;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CUR,
		ST_TGT,
		ST_FIN
	} eng_state_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} eng_stat_t;

endpackage

@@ sv/dssf_engine.sv @@
// Event table and scan sequencer with one shared time/compare unit.
module dssf_engine import dssf_pkg::*; #(
	parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  req_t               req,
	input  logic [COUNT_W-1:0] count,
	input  logic               res_take,
	output eng_stat_t          stat,
	output rsp_t               res
);

	localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int XW = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_EVENTS);
	localparam logic [TIME_W-1:0] DAY_T = TIME_W'(DAY_MINUTES);

	entry_t mem [MAX_EVENTS];
	entry_t rd_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_entry;

	eng_state_t state_q, state_d;
	logic [IW-1:0]      j_q, j_d, cur_q, cur_d, last, nxt_c;
	logic [COUNT_W-1:0] n_q, n_d;
	logic [TIME_W-1:0]  now_q, now_d;
	rsp_t               res_q, res_d;
	logic [XW-1:0]      count_x, n_eff, cur_inc;

	// shared unit: minutes of day, compare against now, saturated difference
	logic [4:0]        op_hour;
	logic [5:0]        op_min;
	logic [TIME_W-1:0] op_time, op_a, op_diff, op_left;
	logic              op_gt;

	always_comb begin
		if (state_q == ST_IDLE) begin
			op_hour = req.now_hour;
			op_min  = req.now_minute;
		end else begin
			op_hour = rd_q.hour;
			op_min  = rd_q.minute;
		end
		op_time = TIME_W'(op_hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(op_min);
		op_a    = (state_q == ST_CUR) ? DAY_T : op_time;
		op_gt   = op_a > now_q;
		op_diff = op_a - now_q;
		if (!op_gt) begin
			op_left = '0;
		end else if (op_diff > DAY_T) begin
			op_left = DAY_T;
		end else begin
			op_left = op_diff;
		end
	end

	assign count_x = XW'(count);
	assign n_eff   = (count_x > MAX_X) ? MAX_X : count_x;
	assign last    = IW'(n_q - COUNT_W'(1));
	assign cur_inc = XW'(cur_q) + XW'(1);
	assign nxt_c   = (cur_inc >= XW'(n_q)) ? '0 : IW'(cur_inc);

	always_comb begin
		state_d  = state_q;
		j_d      = j_q;
		cur_d    = cur_q;
		n_d      = n_q;
		now_d    = now_q;
		res_d    = res_q;
		rd_addr  = j_q;
		wr_en    = 1'b0;
		wr_addr  = IW'(req.entry_index);
		wr_entry = '{hour: req.event_hour, minute: req.event_minute, on: req.event_on};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req.op == OP_LOAD) begin
						wr_en = XW'(req.entry_index) < MAX_X;
					end else begin
						n_d     = COUNT_W'(n_eff);
						now_d   = op_time;
						j_d     = '0;
						rd_addr = '0;
						if (n_eff == '0) begin
							res_d   = '0;
							res_d.table_empty = 1'b1;
							state_d = ST_FIN;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (op_gt) begin
					cur_d   = (j_q == '0) ? last : j_q - IW'(1);
					rd_addr = cur_d;
					state_d = ST_CUR;
				end else if (j_q == last) begin
					cur_d   = last;
					rd_addr = last;
					state_d = ST_CUR;
				end else begin
					j_d     = j_q + IW'(1);
					rd_addr = j_d;
				end
			end
			ST_CUR: begin
				res_d.current_index = 3'(cur_q);
				res_d.next_index    = 3'(nxt_c);
				res_d.relay_on      = rd_q.on;
				res_d.minutes_left  = '0;
				res_d.table_empty   = 1'b0;
				if (!rd_q.on) begin
					state_d = ST_FIN;
				end else if (nxt_c == '0) begin
					res_d.minutes_left = op_left;
					state_d = ST_FIN;
				end else begin
					rd_addr = nxt_c;
					state_d = ST_TGT;
				end
			end
			ST_TGT: begin
				res_d.minutes_left = op_left;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		j_q   <= j_d;
		cur_q <= cur_d;
		n_q   <= n_d;
		now_q <= now_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

	assign stat.ready     = (state_q == ST_IDLE);
	assign stat.res_valid = (state_q == ST_FIN);
	assign res            = res_q;

endmodule

@@ sv/daily_schedule_slot_finder_unit.sv @@
// Top level of the daily schedule slot finder: config register, engine, result register.
//
// Request channel (req_valid/req_ready, payload req): a transaction with op load writes
// one event {hour, minute, on} into slot entry_index; slots at or above MAX_EVENTS drop
// the write. A load gives no response. A transaction with op
// evaluate gives the current time and yields exactly one response transaction.
// Evaluate: the engine walks the table one entry per cycle through a single registered
// read port until it meets an entry later than the given time or the last entry in use;
// it then reads back the current entry and, when the relay is on and the next event is
// not index 0, the next entry for its time, and registers the result in the engine.
// An empty program skips the walk. req_ready is low while an evaluate is in work, so
// a new evaluate is taken only after the last result has left the engine; while idle,
// loads are taken every cycle.
// Response channel (rsp_valid/rsp_ready, payload rsp): an output register holds the
// result; while the receiver stalls, the block keeps taking loads until it takes one more
// evaluate, then holds that finished result in the engine until the register frees.
// Config: wr_en/wr_data write event_count; write only while idle.
// Reset (arst_n low): event_count clears to 0, no transaction is pending. The event
// table is not cleared; load every slot in use before evaluating.
`include "daily_schedule_slot_finder_unit_defines.svh"

module daily_schedule_slot_finder_unit import dssf_pkg::*; #(
	parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               wr_en,
	input  logic [COUNT_W-1:0] wr_data
);

	logic [COUNT_W-1:0] count_q;
	logic               req_accept;
	logic               res_take;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               eng_res;
	eng_stat_t          eng_stat;

	// hold the event count; the user must write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= wr_data;
		end
	end

	assign req_ready  = eng_stat.ready;
	assign req_accept = req_valid && req_ready;

	dssf_engine #(
		.MAX_EVENTS(MAX_EVENTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_accept),
		.req      (req),
		.count    (count_q),
		.res_take (res_take),
		.stat     (eng_stat),
		.res      (eng_res)
	);

	// advance a finished result into the output register once it is free
	assign res_take = eng_stat.res_valid && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= eng_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an evaluate keeps the request side closed for at least the next cycle
	`DSSF_ASSERT_NEXT(a_eval_busy, req_accept && (req.op == OP_EVAL), !req_ready)
	// an empty program answers with all other fields zero
	`DSSF_ASSERT_SAME(a_empty_zero, rsp_valid && rsp.table_empty,
		(rsp.current_index == 3'd0) && (rsp.next_index == 3'd0) && !rsp.relay_on
		&& (rsp.minutes_left == 11'd0))
	// minutes left is zero with the relay off and never beyond one day
	`DSSF_ASSERT_SAME(a_left_range, rsp_valid,
		(rsp.relay_on || (rsp.minutes_left == 11'd0))
		&& (rsp.minutes_left <= 11'(DAY_MINUTES)))
	// the next event follows the current one or wraps to index 0
	`DSSF_ASSERT_SAME(a_next_follows, rsp_valid && !rsp.table_empty,
		(rsp.next_index == 3'd0) || (rsp.next_index == rsp.current_index + 3'd1))

endmodule

@@ tb/sv/daily_schedule_slot_finder_unit_test.sv @@
// Self-checking testbench for the daily schedule slot finder with a mirrored daily program.
`timescale 1ns / 100ps

module daily_schedule_slot_finder_unit_test import dssf_pkg::*;;

	// Program size for each random phase, four bits per phase, phase 0 in the low nibble.
	// Zero, eight and fifteen cover the empty program, a full one and a count past capacity.
	localparam logic [39:0] PHASE_COUNTS = {4'd9, 4'd7, 4'd2, 4'd12, 4'd5,
	                                        4'd8, 4'd0, 4'd3, 4'd15, 4'd1};
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int SETTLE_CYCLES   = 16;
	localparam int BACKLOG_AT      = 40;
	localparam int BACKLOG_CYCLES  = 400;
	localparam longint RUN_LIMIT_NS = 5_000_000;

	// Mirror of the block: its own copy of the program and the event count, and the
	// queue of responses still owed by the block, oldest first.
	class schedule_mirror;
		entry_t            slots [MAX_EVENTS_DEF];
		logic [COUNT_W-1:0] event_count;
		rsp_t              due_results [$];
		int                mismatches;

		function new();
			foreach (slots[i]) slots[i] = '0;
			event_count = '0;
			mismatches  = 0;
		endfunction

		function int minute_of_day(entry_t e);
			return int'(e.hour) * MIN_PER_HOUR + int'(e.minute);
		endfunction

		function void set_count(logic [COUNT_W-1:0] value);
			event_count = value;
		endfunction

		// Work out which event is in force at the given time and how long it lasts.
		function rsp_t locate_slot(req_t r);
			int   n, now_t, reached, j, cur, nxt, target, left;
			rsp_t res;
			res = '0;
			n = (int'(event_count) > MAX_EVENTS_DEF) ? MAX_EVENTS_DEF : int'(event_count);
			if (n == 0) begin
				res.table_empty = 1'b1;
				return res;
			end
			now_t = int'(r.now_hour) * MIN_PER_HOUR + int'(r.now_minute);
			// walk the program in order, stop at the first event still ahead
			reached = 0;
			for (j = 0; j < n; j++) begin
				if (minute_of_day(slots[j]) > now_t) break;
				reached = j + 1;
			end
			// nothing reached yet: the last event of the day is still in force
			cur = (reached == 0) ? n - 1 : reached - 1;
			nxt = (cur + 1 >= n) ? 0 : cur + 1;
			left = 0;
			if (slots[cur].on) begin
				// wrapping to the first event means counting to midnight
				target = (nxt == 0) ? DAY_MINUTES : minute_of_day(slots[nxt]);
				left = (target > now_t) ? target - now_t : 0;
				if (left > DAY_MINUTES) left = DAY_MINUTES;
			end
			res.current_index = 3'(cur);
			res.next_index    = 3'(nxt);
			res.relay_on      = slots[cur].on;
			res.minutes_left  = 11'(left);
			return res;
		endfunction

		// Note one accepted request transaction.
		function void note_request(req_t r);
			if (r.op == OP_LOAD) begin
				if (int'(r.entry_index) < MAX_EVENTS_DEF)
					slots[r.entry_index] = '{hour: r.event_hour, minute: r.event_minute,
					                         on: r.event_on};
			end else begin
				due_results.push_back(locate_slot(r));
			end
		endfunction

		// Compare one accepted response transaction with the oldest owed one.
		function void check_response(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("%0t: response with none owed: ", $time);
					$display("cur %0d next %0d relay %0b left %0d empty %0b",
					         got.current_index, got.next_index, got.relay_on,
					         got.minutes_left, got.table_empty);
				end
				return;
			end
			want = due_results.pop_front();
			if (got.current_index !== want.current_index || got.next_index !== want.next_index ||
			    got.relay_on !== want.relay_on || got.minutes_left !== want.minutes_left ||
			    got.table_empty !== want.table_empty) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("%0t: want cur %0d next %0d relay %0b left %0d empty %0b",
					       $time, want.current_index, want.next_index, want.relay_on,
					       want.minutes_left, want.table_empty);
					$display(", got cur %0d next %0d relay %0b left %0d empty %0b",
					         got.current_index, got.next_index, got.relay_on,
					         got.minutes_left, got.table_empty);
				end
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	req_t               req;
	logic               rsp_valid;
	logic               rsp_ready;
	rsp_t               rsp;
	logic               wr_en;
	logic [COUNT_W-1:0] wr_data;

	schedule_mirror mirror = new();
	bit             steady;        // phase with no idling on either side
	bit             backlog_done;
	int             results_seen;

	daily_schedule_slot_finder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length: mostly none or a few cycles, now and then a long pause.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Load transaction; the time fields are don't-care, so fill them with noise.
	function automatic req_t load_req(input int slot, input int hr, input int mn, input bit on);
		req_t r;
		r.op           = OP_LOAD;
		r.entry_index  = 3'(slot);
		r.event_hour   = 5'(hr);
		r.event_minute = 6'(mn);
		r.event_on     = on;
		r.now_hour     = 5'($urandom);
		r.now_minute   = 6'($urandom);
		return r;
	endfunction

	// Evaluate transaction; the event fields are don't-care, so fill them with noise.
	function automatic req_t eval_req(input int hr, input int mn);
		req_t r;
		r.op           = OP_EVAL;
		r.entry_index  = 3'($urandom);
		r.event_hour   = 5'($urandom);
		r.event_minute = 6'($urandom);
		r.event_on     = 1'($urandom);
		r.now_hour     = 5'(hr);
		r.now_minute   = 6'(mn);
		return r;
	endfunction

	// Offer one request transaction after a random gap and hold it until accepted.
	// With no gap, valid stays high straight into the next transaction.
	task automatic offer(input req_t item);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		mirror.note_request(item);
	endtask

	// Drain the block, let a trailing load finish, then write the event count.
	task automatic write_count(input logic [COUNT_W-1:0] value);
		req_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en   <= 1'b1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		mirror.set_count(value);
	endtask

	// Load all eight slots: mostly a sorted day of in-range times, sometimes raw noise
	// that leaves the program unsorted or out of range.
	task automatic load_program(input bit well_formed);
		int t [$];
		int i;
		for (i = 0; i < MAX_EVENTS_DEF; i++) t.push_back($urandom_range(0, DAY_MINUTES - 1));
		t.sort();
		for (i = 0; i < MAX_EVENTS_DEF; i++) begin
			if (well_formed)
				offer(load_req(i, t[i] / MIN_PER_HOUR, t[i] % MIN_PER_HOUR,
				               $urandom_range(0, 1)));
			else
				offer(load_req(i, $urandom_range(0, 31), $urandom_range(0, 63),
				               $urandom_range(0, 1)));
		end
	endtask

	// Response side: check every accepted response, stall at random, and once hold off
	// for a long stretch so the block backs up and drops req_ready.
	initial begin : response_side
		int hold;
		hold = 0;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				mirror.check_response(rsp);
				results_seen++;
			end
			if (results_seen == BACKLOG_AT && !backlog_done) begin
				backlog_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(posedge clk);
				hold = 0;
			end else begin
				if (hold != 0) hold--;
				else if (!steady && $urandom_range(0, 3) == 0) hold = idle_len();
				rsp_ready <= (hold == 0);
			end
		end
	end

	// Request side: reset, directed cases, then random phases.
	initial begin : request_side
		int phase, k, r, hr, mn, v;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		wr_en     <= 1'b0;
		wr_data   <= '0;
		steady    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty program straight out of reset, at the largest time the fields allow.
		offer(eval_req(31, 63));

		// A sorted day, extremes of the event fields come later.
		offer(load_req(0, 1, 0, 1));
		offer(load_req(1, 6, 30, 0));
		offer(load_req(2, 8, 0, 1));
		offer(load_req(3, 12, 0, 1));
		offer(load_req(4, 17, 45, 0));
		offer(load_req(5, 20, 0, 1));
		offer(load_req(6, 22, 0, 0));
		offer(load_req(7, 23, 59, 1));
		write_count(4'd8);
		offer(eval_req(0, 30));   // before the first event: last one in force, to midnight
		offer(eval_req(12, 0));   // exactly on an event
		offer(eval_req(6, 45));   // relay off
		offer(eval_req(23, 59));  // one minute to midnight
		offer(eval_req(31, 63));  // past midnight: minutes left clamps to zero
		offer(eval_req(22, 10));

		// Two events, the second far out of range: minutes left clamps to a full day.
		offer(load_req(0, 0, 0, 1));
		offer(load_req(1, 31, 63, 0));
		write_count(4'd2);
		offer(eval_req(0, 0));
		offer(eval_req(31, 63));

		// Count beyond capacity acts as a full program.
		write_count(4'd15);
		offer(eval_req(12, 0));

		for (phase = 0; phase < PHASES; phase++) begin
			write_count(PHASE_COUNTS[phase * COUNT_W +: COUNT_W]);
			steady = (phase % 4 == 2);
			load_program($urandom_range(0, 3) != 0);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					// stray load into the running program
					if ($urandom_range(0, 3) == 0)
						offer(load_req($urandom_range(0, 7), $urandom_range(0, 31),
						               $urandom_range(0, 63), $urandom_range(0, 1)));
					else
						offer(load_req($urandom_range(0, 7), $urandom_range(0, 23),
						               $urandom_range(0, 59), $urandom_range(0, 1)));
				end else if (r < 25) begin
					offer(eval_req($urandom_range(0, 31), $urandom_range(0, 63)));
				end else if (r < 50) begin
					// land on an event boundary or one minute short of it
					v = mirror.minute_of_day(mirror.slots[$urandom_range(0, 7)]) -
					    $urandom_range(0, 1);
					if (v < 0) v = 0;
					hr = v / MIN_PER_HOUR;
					mn = v % MIN_PER_HOUR;
					offer(eval_req(hr, mn));
				end else begin
					offer(eval_req($urandom_range(0, 23), $urandom_range(0, 59)));
				end
			end
		end
		steady = 1'b0;

		// Drain, then give the block time to show any stray response.
		req_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
